@@ sv/buddy_block_allocator_defines.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the buddy allocator
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(label, clk, rst, prop, msg)
`define BBA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ sv/bba_pkg.sv @@
// ---------------------------------------------------------------------------
// bba_pkg
// types and constants of the buddy block allocator
// ---------------------------------------------------------------------------
package bba_pkg;
   localparam int MemoryUnits = 1024;
   localparam int HandleCount = 64;
   localparam int TopLevel    = $clog2(MemoryUnits + 1) - 1;
   localparam int Units       = 1 << TopLevel;
   localparam int OffW        = 10;
   localparam int SizeW       = 11;
   localparam int LevW        = 4;
   localparam int Levels      = TopLevel + 1;
   localparam int SlotW       = $clog2(2 * Units);
   localparam int CntW        = TopLevel + 1;
   localparam int HandleW     = 6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_IN_USE  = 3'd1;
   localparam logic [2:0] ST_BAD_AMT = 3'd2;
   localparam logic [2:0] ST_NO_MEM  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_HRD, S_HCHK, S_FIND, S_SPLIT_RD, S_SPLIT_WR, S_GRANT_RD, S_GRANT,
      S_MRG_RD, S_MRG_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PUSH, S_DONE
   } state_type;

   function automatic logic [CntW-1:0] cap_of(input logic [LevW-1:0] k);
      cap_of = CntW'(Units >> k);
   endfunction

   function automatic logic [SlotW-1:0] base_of(input logic [LevW-1:0] k);
      base_of = SlotW'(2 * Units) - SlotW'({cap_of(k), 1'b0});
   endfunction
endpackage

@@ sv/bba_ram.sv @@
// ---------------------------------------------------------------------------
// bba_ram
// generic single-port synchronous ram, registered read data
// ---------------------------------------------------------------------------
module bba_ram #(
   parameter int Depth = 2048,
   parameter int Width = 10
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ sv/buddy_block_allocator.sv @@
// ---------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over a power-of-two region with fifo free lists per level
// ---------------------------------------------------------------------------
// usage: the req_ channel carries kind (0 allocate, 1 free), handle and
// amount; the rsp_ channel returns status, offset and block_size, one
// transfer per request. the free lists live in one ram of 2*units entries
// and the handle table in a second ram, each with one port, so every queue
// access is a separate ram read or write. a granted allocate takes longer
// for each level it walks up and splits, and a free takes longer for each
// queue entry scanned or shifted and each level merged. one request is in
// flight at a time; req_stall stays high until the response register is
// empty again. while rsp_stall is high the response holds and no new
// request is taken. after reset the block holds one free block of the whole
// region at offset 0; the first cycle after reset writes that entry into
// the ram and req_stall is high.
// ---------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [HandleW-1:0] req_handle,
   input  logic [11:0]        req_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [OffW-1:0]    rsp_offset,
   output logic [SizeW-1:0]   rsp_block_size
);
`include "buddy_block_allocator_defines.svh"

   localparam int HW = $clog2(HandleCount);
   localparam int HEntW = OffW + LevW;

   state_type state_ff, state_in;
   logic init_ff, init_in;
   logic kind_ff, kind_in;
   logic [HandleW-1:0] handle_ff, handle_in;
   logic [LevW-1:0] need_ff, need_in, lev_ff, lev_in;
   logic [OffW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] head_ff [Levels];
   logic [CntW-1:0] cnt_ff [Levels];
   logic [HandleCount-1:0] hvalid_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;
   logic [OffW-1:0] roff_ff, roff_in;
   logic [SizeW-1:0] rsize_ff, rsize_in;

   logic fq_we;
   logic [SlotW-1:0] fq_addr;
   logic [OffW-1:0] fq_wdata, fq_rdata;
   logic ht_we;
   logic [HW-1:0] ht_addr;
   logic [HEntW-1:0] ht_wdata, ht_rdata;

   // queue control
   logic head_we, cnt_inc, cnt_dec, hv_set, hv_clr;
   logic [LevW-1:0] q_lev;

   bba_ram #(.Depth(2 * Units), .Width(OffW)) u_fq (
      .clock(clock), .we(fq_we), .addr(fq_addr), .wdata(fq_wdata), .rdata(fq_rdata));
   bba_ram #(.Depth(HandleCount), .Width(HEntW)) u_ht (
      .clock(clock), .we(ht_we), .addr(ht_addr), .wdata(ht_wdata), .rdata(ht_rdata));

   logic req_xfer, rsp_xfer;
   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff || init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_offset = roff_ff;
   assign rsp_block_size = rsize_ff;

   function automatic logic [SlotW-1:0] slot(input logic [LevW-1:0] k,
                                              input logic [CntW-1:0] h,
                                              input logic [CntW-1:0] i);
      logic [CntW-1:0] m;
      m = (h + i) & (cap_of(k) - CntW'(1));
      slot = base_of(k) + SlotW'(m);
   endfunction

   logic [LevW-1:0] need_c;
   logic [LevW-1:0] lvl1;
   logic [CntW-1:0] cur_cnt;
   logic [OffW-1:0] buddy;
   logic hit_valid;

   always_comb begin
      need_c = '0;
      for (int b = 0; b < 13; b++)
         if (b > 0 && (12'd1 << (b - 1)) < req_amount) need_c = LevW'(b);
      lvl1 = lev_ff + LevW'(1);
      cur_cnt = cnt_ff[lev_ff];
      buddy = pos_ff ^ (OffW'(1) << lev_ff);
      hit_valid = (int'(handle_ff) < HandleCount) ? hvalid_ff[handle_ff[HW-1:0]] : 1'b0;
   end

   always_comb begin
      state_in = state_ff; init_in = 1'b0;
      kind_in = kind_ff; handle_in = handle_ff; need_in = need_ff; lev_in = lev_ff;
      pos_in = pos_ff; idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      status_in = status_ff; roff_in = roff_ff; rsize_in = rsize_ff;
      fq_we = 1'b0; fq_addr = '0; fq_wdata = '0;
      ht_we = 1'b0; ht_addr = handle_ff[HW-1:0];
      ht_wdata = {pos_ff, lev_ff};
      head_we = 1'b0; cnt_inc = 1'b0; cnt_dec = 1'b0; q_lev = lev_ff;
      hv_set = 1'b0; hv_clr = 1'b0;
      if (init_ff) begin
         fq_we = 1'b1; fq_addr = base_of(LevW'(TopLevel)); fq_wdata = '0;
      end
      case (state_ff)
         S_IDLE: if (req_xfer) begin
            kind_in = req_kind; handle_in = req_handle; need_in = need_c;
            state_in = S_HRD;
            if (req_amount > 12'(Units)) need_in = LevW'(TopLevel + 1);
            idx_in = (req_amount == 12'd0) ? CntW'(1) : CntW'(0);
         end
         S_HRD: begin
            ht_addr = handle_ff[HW-1:0];
            state_in = S_HCHK;
         end
         S_HCHK: begin
            roff_in = '0; rsize_in = '0;
            if (int'(handle_ff) >= HandleCount) begin
               status_in = ST_UNKNOWN; state_in = S_DONE;
            end else if (kind_ff == 1'b0) begin
               if (hit_valid) begin status_in = ST_IN_USE; state_in = S_DONE; end
               else if (idx_ff == CntW'(1)) begin
                  status_in = ST_BAD_AMT; state_in = S_DONE;
               end else if (need_ff > LevW'(TopLevel)) begin
                  status_in = ST_NO_MEM; state_in = S_DONE;
               end else begin
                  lev_in = need_ff; state_in = S_FIND;
               end
            end else begin
               if (!hit_valid) begin status_in = ST_UNKNOWN; state_in = S_DONE; end
               else begin
                  hv_clr = 1'b1;
                  pos_in = ht_rdata[HEntW-1:LevW]; lev_in = ht_rdata[LevW-1:0];
                  status_in = ST_OK; roff_in = ht_rdata[HEntW-1:LevW];
                  rsize_in = SizeW'(1) << ht_rdata[LevW-1:0];
                  idx_in = '0; state_in = S_MRG_RD;
               end
            end
         end
         S_FIND: begin
            if (lev_ff > LevW'(TopLevel)) begin
               status_in = ST_NO_MEM; state_in = S_DONE;
            end else if (cur_cnt != '0) begin
               state_in = (lev_ff == need_ff) ? S_GRANT_RD : S_SPLIT_RD;
            end else lev_in = lvl1;
         end
         S_SPLIT_RD: begin
            fq_addr = slot(lev_ff, head_ff[lev_ff], '0);
            head_we = 1'b1; cnt_dec = 1'b1; idx_in = '0;
            state_in = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            // two pushes one level down, lower half first
            if (idx_ff == '0) begin
               pos_in = fq_rdata;
               q_lev = lev_ff - LevW'(1);
               fq_we = 1'b1;
               fq_addr = slot(q_lev, head_ff[q_lev], cnt_ff[q_lev]);
               fq_wdata = fq_rdata; cnt_inc = 1'b1; idx_in = CntW'(1);
            end else begin
               q_lev = lev_ff - LevW'(1);
               fq_we = 1'b1;
               fq_addr = slot(q_lev, head_ff[q_lev], cnt_ff[q_lev]);
               fq_wdata = pos_ff + (OffW'(1) << q_lev); cnt_inc = 1'b1;
               lev_in = q_lev;
               state_in = (q_lev == need_ff) ? S_GRANT_RD : S_SPLIT_RD;
            end
         end
         S_GRANT_RD: begin
            fq_addr = slot(lev_ff, head_ff[lev_ff], '0);
            head_we = 1'b1; cnt_dec = 1'b1; state_in = S_GRANT;
         end
         S_GRANT: begin
            ht_we = 1'b1; ht_wdata = {fq_rdata, lev_ff}; hv_set = 1'b1;
            status_in = ST_OK; roff_in = fq_rdata; rsize_in = SizeW'(1) << lev_ff;
            state_in = S_DONE;
         end
         S_MRG_RD: begin
            if (lev_ff >= LevW'(TopLevel) || idx_ff >= cur_cnt) state_in = S_PUSH;
            else begin
               fq_addr = slot(lev_ff, head_ff[lev_ff], idx_ff);
               state_in = S_MRG_CMP;
            end
         end
         S_MRG_CMP: begin
            if (fq_rdata == buddy) state_in = S_SHIFT_RD;
            else begin idx_in = idx_ff + CntW'(1); state_in = S_MRG_RD; end
         end
         S_SHIFT_RD: begin
            if (idx_ff + CntW'(1) >= cur_cnt) begin
               cnt_dec = 1'b1;
               if (buddy < pos_ff) pos_in = buddy;
               lev_in = lvl1; idx_in = '0; state_in = S_MRG_RD;
            end else begin
               fq_addr = slot(lev_ff, head_ff[lev_ff], idx_ff + CntW'(1));
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            fq_we = 1'b1; fq_addr = slot(lev_ff, head_ff[lev_ff], idx_ff);
            fq_wdata = fq_rdata; idx_in = idx_ff + CntW'(1); state_in = S_SHIFT_RD;
         end
         S_PUSH: begin
            fq_we = 1'b1; fq_addr = slot(lev_ff, head_ff[lev_ff], cur_cnt);
            fq_wdata = pos_ff; cnt_inc = 1'b1; state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; init_ff <= 1'b1; rsp_valid_ff <= 1'b0; hvalid_ff <= '0;
         for (int i = 0; i < Levels; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i] <= (i == TopLevel) ? CntW'(1) : '0;
         end
      end else begin
         state_ff <= state_in; init_ff <= init_in; rsp_valid_ff <= rsp_valid_in;
         if (hv_set) hvalid_ff[handle_ff[HW-1:0]] <= 1'b1;
         if (hv_clr) hvalid_ff[handle_ff[HW-1:0]] <= 1'b0;
         if (head_we)
            head_ff[q_lev] <= (head_ff[q_lev] + CntW'(1)) & (cap_of(q_lev) - CntW'(1));
         if (cnt_inc) cnt_ff[q_lev] <= cnt_ff[q_lev] + CntW'(1);
         if (cnt_dec) cnt_ff[q_lev] <= cnt_ff[q_lev] - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; handle_ff <= handle_in; need_ff <= need_in; lev_ff <= lev_in;
      pos_ff <= pos_in; idx_ff <= idx_in;
      status_ff <= status_in; roff_ff <= roff_in; rsize_ff <= rsize_in;
   end

   `BBA_ASSERT(a_one_inflight, clock, reset, rsp_valid_ff |-> state_ff == S_IDLE,
               "response pending while busy")
   `BBA_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff,
               "response dropped under stall")
   `BBA_ASSERT(a_err_zero, clock, reset, (rsp_valid_ff && status_ff != ST_OK) |->
               (roff_ff == '0 && rsize_ff == '0), "error with nonzero payload")
endmodule
